@@ hdl/distance_false_color_map_top_defines.svh @@
// ----------------------------------------------------------------------------
// distance false colour map - assertion macros
// shared property wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef DISTANCE_FALSE_COLOR_MAP_TOP_DEFINES_SVH
`define DISTANCE_FALSE_COLOR_MAP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DFCM_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dfcm assertion failed");
// next-cycle implication
`define DFCM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dfcm assertion failed");
`else
`define DFCM_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define DFCM_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

@@ hdl/dfcm_pkg.sv @@
// ----------------------------------------------------------------------------
// dfcm_pkg
// shared constants, command and status types and colour mapping functions
// ----------------------------------------------------------------------------
package dfcm_pkg;

    localparam int DIST_WIDTH = 32;
    localparam int DIV_STEPS  = 17;

    localparam logic [16:0] Q_ONE = 17'd65536;

    // floor(x*65536/100) == (x*PCT_RECIP) >> PCT_SHIFT for x up to 100
    localparam logic [23:0] PCT_RECIP = 24'd10737419;
    localparam int          PCT_SHIFT = 14;
    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic signed [17:0] LO_NEG_THR = -18'sd655;

    localparam logic [1:0] CFG_WIN_LOW  = 2'd0;
    localparam logic [1:0] CFG_WIN_HIGH = 2'd1;
    localparam logic [1:0] CFG_MODE     = 2'd2;
    localparam logic [1:0] CFG_DEF_RGB  = 2'd3;

    localparam logic [3:0] MODE_RGB     = 4'd0;
    localparam logic [3:0] MODE_YEL_RED = 4'd1;
    localparam logic [3:0] MODE_GRAY    = 4'd2;
    localparam logic [3:0] MODE_CMYK    = 4'd3;
    localparam logic [3:0] MODE_HEAT    = 4'd4;
    localparam logic [3:0] MODE_PASTEL  = 4'd5;
    localparam logic [3:0] MODE_RAINBOW = 4'd6;
    localparam logic [3:0] MODE_DEFAULT = 4'd7;
    localparam logic [3:0] MODE_WHITE   = 4'd8;

    typedef struct packed {
        logic gather;
        logic capture;
        logic norm;
        logic window;
        logic div_step;
        logic div_to_c;
        logic load_out;
    } dfcm_cmd_t;

    typedef struct packed {
        logic norm_direct;
        logic win_direct;
        logic div_last;
        logic out_busy;
    } dfcm_sts_t;

    function automatic logic [7:0] ramp_255(input logic [16:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd255;
        return p[24] ? 8'd255 : p[23:16];
    endfunction

    function automatic logic [7:0] ramp_1020(input logic [16:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd1020;
        return (|p[26:24]) ? 8'd255 : p[23:16];
    endfunction

    function automatic logic [7:0] cmyk_chan(input logic [16:0] v);
        logic [32:0] p1;
        logic [40:0] p2;
        p1 = 33'(v) * 33'd52429;
        p2 = {p1, 8'b0} - 41'(p1);
        return p2[40] ? 8'd255 : p2[39:32];
    endfunction

    function automatic logic [7:0] pastel(input logic [16:0] x);
        logic [22:0] p;
        logic [8:0]  s;
        p = 23'(x) * 23'd55;
        s = 9'd200 + 9'(p[22:16]);
        return s[8] ? 8'd255 : s[7:0];
    endfunction

    function automatic logic [23:0] rainbow(input logic [16:0] c);
        logic [25:0] hp;
        logic [8:0]  h;
        logic [2:0]  sec;
        logic [8:0]  base;
        logic [5:0]  rr;
        logic [13:0] n;
        logic [28:0] up_p;
        logic [7:0]  up;
        logic [7:0]  dn;
        logic [23:0] rgb;
        // c*360 as shift and add
        hp = (26'(c) << 8) + (26'(c) << 6) + (26'(c) << 5) + (26'(c) << 3);
        h = hp[24:16];
        if (h == 9'd360)
        begin
            h = 9'd0;
        end
        if (h >= 9'd300)      begin sec = 3'd5; base = 9'd300; end
        else if (h >= 9'd240) begin sec = 3'd4; base = 9'd240; end
        else if (h >= 9'd180) begin sec = 3'd3; base = 9'd180; end
        else if (h >= 9'd120) begin sec = 3'd2; base = 9'd120; end
        else if (h >= 9'd60)  begin sec = 3'd1; base = 9'd60;  end
        else                  begin sec = 3'd0; base = 9'd0;   end
        rr = 6'(h - base);
        // rounded rr*255/60 via reciprocal
        n = (14'(rr) << 8) - 14'(rr) + 14'd30;
        up_p = 29'(n) * 29'd17477;
        up = up_p[27:20];
        dn = 8'd255 - up;
        case (sec)
            3'd0:    rgb = {8'd255, up, 8'd0};
            3'd1:    rgb = {dn, 8'd255, 8'd0};
            3'd2:    rgb = {8'd0, 8'd255, up};
            3'd3:    rgb = {8'd0, dn, 8'd255};
            3'd4:    rgb = {up, 8'd0, 8'd255};
            default: rgb = {8'd255, 8'd0, dn};
        endcase
        return rgb;
    endfunction

    function automatic logic [23:0] map_colour(input logic [16:0] c,
                                               input logic [3:0]  mode,
                                               input logic [23:0] drgb);
        logic [16:0] inv;
        logic [18:0] c3;
        logic [16:0] m_arg;
        logic [16:0] y_arg;
        logic [23:0] rgb;
        inv = Q_ONE - c;
        c3 = (19'(c) << 1) + 19'(c);
        m_arg = Q_ONE - c3[18:2];
        y_arg = Q_ONE - (inv >> 1);
        case (mode)
            MODE_RGB:
            begin
                if (c <= 17'd16384)
                    rgb = {8'd255, ramp_1020(c), 8'd0};
                else if (c <= 17'd32768)
                    rgb = {ramp_1020(17'd32768 - c), 8'd255, 8'd0};
                else if (c <= 17'd49152)
                    rgb = {8'd0, 8'd255, ramp_1020(c - 17'd32768)};
                else
                    rgb = {8'd0, ramp_1020(inv), 8'd255};
            end
            MODE_YEL_RED: rgb = {8'd255, ramp_255(inv), 8'd0};
            MODE_GRAY:    rgb = {ramp_255(c), ramp_255(c), ramp_255(c)};
            MODE_CMYK:    rgb = {cmyk_chan(c), cmyk_chan(m_arg), cmyk_chan(y_arg)};
            MODE_HEAT:    rgb = {ramp_255(c), 8'd0, ramp_255(inv)};
            MODE_PASTEL:  rgb = {8'd255, pastel(c), pastel(inv)};
            MODE_RAINBOW: rgb = rainbow(c);
            MODE_DEFAULT: rgb = drgb;
            MODE_WHITE:   rgb = 24'hFFFFFF;
            default:      rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

@@ hdl/dfcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// dfcm_ctrl
// sequencer for gather items and the colour pass: normalise, window, map and hand over
// ----------------------------------------------------------------------------
module dfcm_ctrl import dfcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      dist_valid,
    input  logic      phase,
    output logic      dist_stall,
    input  dfcm_sts_t sts,
    output dfcm_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV1,
        S_WIN,
        S_DIV2,
        S_MAP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   accept;

    assign accept     = dist_valid && !stall_reg;
    assign dist_stall = stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.gather  = accept && !phase;
                cmd.capture = accept && phase;
                if (accept && phase)
                    state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = sts.norm_direct ? S_WIN : S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_WIN;
            end
            S_WIN:
            begin
                cmd.window = 1'b1;
                state_next = sts.win_direct ? S_MAP : S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_step = 1'b1;
                cmd.div_to_c = 1'b1;
                if (sts.div_last)
                    state_next = S_MAP;
            end
            S_MAP:
            begin
                // wait for the output register to drain
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

endmodule

@@ hdl/dfcm_datapath.sv @@
// ----------------------------------------------------------------------------
// dfcm_datapath
// config registers, min and max tracking, shared serial divider, window
// thresholds, colour lookup and output register
// ----------------------------------------------------------------------------
module dfcm_datapath import dfcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic [31:0] distance,
    input  logic        first,
    input  dfcm_cmd_t   cmd,
    output dfcm_sts_t   sts,
    input  logic        color_stall,
    output logic        color_valid,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic [6:0]  win_low_reg;
    logic [6:0]  win_high_reg;
    logic [3:0]  mode_reg;
    logic [23:0] drgb_reg;

    logic [DIST_WIDTH-1:0] min_reg;
    logic [DIST_WIDTH-1:0] max_reg;
    logic [DIST_WIDTH-1:0] d;
    logic [DIST_WIDTH-1:0] d_reg;

    logic [6:0]  lo_pct;
    logic [6:0]  hi_pct;
    logic [30:0] lo_prod_reg;
    logic [30:0] hi_prod_reg;
    logic        lo_neg_reg;
    logic signed [17:0] lo_thr;
    logic signed [17:0] hi_thr;
    logic signed [17:0] fs;
    logic signed [17:0] win_num;
    logic signed [17:0] win_den;

    logic [16:0] f_reg;
    logic [16:0] c_reg;
    logic [16:0] f_direct;
    logic        flat_or_low;

    logic [DIST_WIDTH:0]   rem_reg;
    logic [DIST_WIDTH-1:0] dvs_reg;
    logic [16:0]           quo_reg;
    logic [4:0]            cnt_reg;
    logic [DIST_WIDTH:0]   trial;
    logic [DIST_WIDTH:0]   dvs_ext;
    logic                  ge;
    logic [DIST_WIDTH:0]   rem_next;
    logic [16:0]           quo_next;

    logic        color_valid_reg;
    logic [23:0] rgb_reg;

    assign d = distance[DIST_WIDTH-1:0];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= 7'd0;
            win_high_reg <= PCT_MAX;
            mode_reg     <= MODE_RGB;
            drgb_reg     <= 24'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIN_LOW:  win_low_reg  <= cfg_data[6:0];
                CFG_WIN_HIGH: win_high_reg <= cfg_data[6:0];
                CFG_MODE:     mode_reg     <= cfg_data[3:0];
                CFG_DEF_RGB:  drgb_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // running min and max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else if (cmd.gather)
        begin
            if (first)
            begin
                min_reg <= d;
                max_reg <= d;
            end
            else
            begin
                if (d < min_reg)
                    min_reg <= d;
                if (d > max_reg)
                    max_reg <= d;
            end
        end
    end

    // window thresholds
    assign lo_pct = (win_low_reg > PCT_MAX) ? PCT_MAX : win_low_reg;
    assign hi_pct = (win_high_reg > PCT_MAX) ? PCT_MAX : win_high_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            d_reg       <= d;
            lo_neg_reg  <= (lo_pct == 7'd0);
            lo_prod_reg <= 31'(lo_pct - 7'd1) * 31'(PCT_RECIP);
            hi_prod_reg <= 31'(hi_pct) * 31'(PCT_RECIP);
        end
    end

    // a zero low handle truncates toward zero
    assign lo_thr = lo_neg_reg ? LO_NEG_THR
                               : $signed({1'b0, lo_prod_reg[PCT_SHIFT+16:PCT_SHIFT]});
    assign hi_thr = $signed({1'b0, hi_prod_reg[PCT_SHIFT+16:PCT_SHIFT]});
    assign fs     = $signed({1'b0, f_reg});
    assign win_num = fs - lo_thr;
    assign win_den = hi_thr - lo_thr;

    assign flat_or_low = (max_reg <= min_reg) || (d_reg <= min_reg);
    assign f_direct    = flat_or_low ? 17'd0 : Q_ONE;

    assign sts.norm_direct = flat_or_low || (d_reg >= max_reg);
    assign sts.win_direct  = (fs < lo_thr) || (fs > hi_thr) || (hi_thr <= lo_thr);
    assign sts.div_last    = (cnt_reg == 5'(DIV_STEPS - 1));

    // restoring divider, first step without shift
    assign trial    = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[DIST_WIDTH-1:0], 1'b0};
    assign dvs_ext  = {1'b0, dvs_reg};
    assign ge       = (trial >= dvs_ext);
    assign rem_next = ge ? (trial - dvs_ext) : trial;
    assign quo_next = {quo_reg[15:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else if (cmd.norm || cmd.window)
        begin
            cnt_reg <= 5'd0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.norm)
        begin
            f_reg   <= f_direct;
            rem_reg <= {1'b0, d_reg - min_reg};
            dvs_reg <= max_reg - min_reg;
            quo_reg <= 17'd0;
        end
        else if (cmd.window)
        begin
            // below the low threshold wins over above the high one
            if ((fs >= lo_thr) && (fs > hi_thr))
                c_reg <= Q_ONE;
            else
                c_reg <= 17'd0;
            rem_reg <= (DIST_WIDTH+1)'(win_num[16:0]);
            dvs_reg <= DIST_WIDTH'(win_den[16:0]);
            quo_reg <= 17'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (sts.div_last)
            begin
                if (cmd.div_to_c)
                    c_reg <= quo_next;
                else
                    f_reg <= quo_next;
            end
        end
    end

    // output register
    assign sts.out_busy = color_valid_reg && color_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            color_valid_reg <= 1'b1;
        end
        else if (!color_stall)
        begin
            color_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            rgb_reg <= map_colour(c_reg, mode_reg, drgb_reg);
    end

    assign color_valid = color_valid_reg;
    assign red         = rgb_reg[23:16];
    assign green       = rgb_reg[15:8];
    assign blue        = rgb_reg[7:0];

endmodule

@@ hdl/distance_false_color_map_top.sv @@
// ----------------------------------------------------------------------------
// distance_false_color_map_top
// maps streamed Q16.16 distances to 8-bit false colours
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  dist      in         dist_valid/dist_stall  distance, phase, first
//  color     out        color_valid/color_stall red, green, blue
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  a gather item is taken without a stall; a colour item holds the input off
//  from its transfer to the next one, with a pass through the shared
//  17-step serial divider for normalise and for window unless either is direct
//  dist_stall is high while a colour item is in work, longer while the output
//  register still holds an unsent colour
//  a finished colour waits in the output register while the next item enters
//  reset clears min to all ones, max to zero and the registers to 0, 100, 0, 0
// ----------------------------------------------------------------------------
`include "distance_false_color_map_top_defines.svh"

module distance_false_color_map_top import dfcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dist_valid,
    output logic        dist_stall,
    input  logic [31:0] distance,
    input  logic        phase,
    input  logic        first,
    output logic        color_valid,
    input  logic        color_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    dfcm_cmd_t cmd;
    dfcm_sts_t sts;

    assign cfg_ready = 1'b1;

    dfcm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dist_valid (dist_valid),
        .phase      (phase),
        .dist_stall (dist_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    dfcm_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .distance    (distance),
        .first       (first),
        .cmd         (cmd),
        .sts         (sts),
        .color_stall (color_stall),
        .color_valid (color_valid),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    // never overwrite a colour still waiting for transfer
    `DFCM_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, !(color_valid && color_stall))
    // divider only runs while inputs are held off
    `DFCM_ASSERT_NOW(a_div_busy, clk, rst_n, cmd.div_step, dist_stall)
    // a colour item blocks the input in the next cycle
    `DFCM_ASSERT_NEXT(a_capture_stalls, clk, rst_n, cmd.capture, dist_stall)
    // a loaded colour is offered in the next cycle
    `DFCM_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, color_valid)

endmodule
